// ===== rtl/sorted_list_priority_queue_macros.svh =====
// Assertion macros for the sorted list priority queue.
// Expects clk and arst_n in the scope of each use.
`ifndef SORTED_LIST_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_LIST_PRIORITY_QUEUE_MACROS_SVH

// Checked only outside reset.
`define SLPQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SLPQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/slpq_pkg.sv =====
// Shared types and constants of the sorted list priority queue.
// No dependencies.
package slpq_pkg;

	localparam int KEY_W = 20;
	localparam int PAY_W = 32;
	localparam int OP_W  = 2;
	localparam int ST_W  = 2;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_POP    = 2'd1,
		OP_LIST   = 2'd2
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Address source of the slot memories for the next read.
	typedef enum logic [1:0] {
		RD_HEAD,
		RD_CUR,
		RD_NEXT
	} rd_sel_t;

	// What the response register is loaded with.
	typedef enum logic [2:0] {
		RES_STORED,
		RES_FULL,
		RES_EMPTY,
		RES_POP,
		RES_LIST
	} res_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_WALK,
		S_LINK_NEW,
		S_LINK_PREV,
		S_STORED,
		S_FULL,
		S_POP,
		S_LIST
	} state_t;

	typedef struct packed {
		logic     accept;     // request taken: latch it, start at head
		rd_sel_t  rd_sel;
		logic     scan_inc;   // free-slot scan moves on
		logic     claim;      // free slot found: write key/payload, mark busy
		logic     step;       // walk moves one node: prev <= cur, cur <= next
		logic     link_new;   // link of new slot <= cur
		logic     head_new;   // head <= new slot
		logic     link_prev;  // link of prev <= new slot
		logic     pop_head;   // free head slot, head <= its link
		logic     out_load;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		logic free_hit;   // slot under scan is free
		logic scan_end;   // scan ran past last slot
		logic cur_nil;
		logic prev_nil;
		logic next_nil;   // link of current node is null
		logic key_less;   // request key below key of current node
		logic out_free;   // response register can take a result
	} sts_t;

endpackage

// ===== rtl/slpq_intf.sv =====
// Request and response channel interfaces of the sorted list priority queue.
// Depends on slpq_pkg.
interface slpq_req_if;
	import slpq_pkg::*;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [KEY_W-1:0]  key;
	logic [PAY_W-1:0]  payload;

	modport source (output valid, op, key, payload, input ready);
	modport sink   (input valid, op, key, payload, output ready);
endinterface

interface slpq_rsp_if;
	import slpq_pkg::*;
	logic              valid;
	logic              ready;
	logic [ST_W-1:0]   status;
	logic [KEY_W-1:0]  out_key;
	logic [PAY_W-1:0]  out_payload;
	logic              last;

	modport source (output valid, status, out_key, out_payload, last, input ready);
	modport sink   (input valid, status, out_key, out_payload, last, output ready);
endinterface

// ===== rtl/slpq_ctrl.sv =====
// Controller state machine of the sorted list priority queue.
// Depends on slpq_pkg; drives the datapath through cmd_t, watches sts_t.
module slpq_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [slpq_pkg::OP_W-1:0]  in_op,
	output logic                       in_ready,
	input  slpq_pkg::sts_t             sts,
	output slpq_pkg::cmd_t             cmd
);
	import slpq_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt   = state_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.rd_sel  = RD_CUR;
		cmd.res_sel = RES_STORED;
		case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.rd_sel = RD_HEAD;
				cmd.accept = in_valid;
				if (in_valid) begin
					case (in_op)
						OP_INSERT: state_nxt = S_SCAN;
						OP_POP:    state_nxt = S_POP;
						OP_LIST:   state_nxt = S_LIST;
						default:   state_nxt = S_IDLE; // unused code: dropped
					endcase
				end
			end
			S_SCAN: begin
				if (sts.scan_end) begin
					state_nxt = S_FULL;
				end else if (sts.free_hit) begin
					cmd.claim = 1'b1;
					state_nxt = S_WALK;
				end else begin
					cmd.scan_inc = 1'b1;
				end
			end
			S_WALK: begin
				// stop at the first node with a larger key, or at the tail
				if (!sts.cur_nil && !sts.key_less) begin
					cmd.step   = 1'b1;
					cmd.rd_sel = RD_NEXT;
				end else begin
					state_nxt = S_LINK_NEW;
				end
			end
			S_LINK_NEW: begin
				cmd.link_new = 1'b1;
				if (sts.prev_nil) begin
					cmd.head_new = 1'b1;
					state_nxt    = S_STORED;
				end else begin
					state_nxt = S_LINK_PREV;
				end
			end
			S_LINK_PREV: begin
				cmd.link_prev = 1'b1;
				state_nxt     = S_STORED;
			end
			S_STORED: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.res_sel  = RES_STORED;
					state_nxt    = S_IDLE;
				end
			end
			S_FULL: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.res_sel  = RES_FULL;
					state_nxt    = S_IDLE;
				end
			end
			S_POP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
					if (sts.cur_nil) begin
						cmd.res_sel = RES_EMPTY;
					end else begin
						cmd.res_sel  = RES_POP;
						cmd.pop_head = 1'b1;
					end
				end
			end
			S_LIST: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.cur_nil) begin
						cmd.res_sel = RES_EMPTY;
						state_nxt   = S_IDLE;
					end else begin
						cmd.res_sel = RES_LIST;
						if (sts.next_nil) begin
							state_nxt = S_IDLE;
						end else begin
							cmd.step   = 1'b1;
							cmd.rd_sel = RD_NEXT;
						end
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/slpq_dp.sv =====
// Datapath of the sorted list priority queue: slot memories, busy map,
// head and walk pointers, response register. Depends on slpq_pkg.
module slpq_dp #(
	parameter int CAPACITY = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  slpq_pkg::cmd_t              cmd,
	output slpq_pkg::sts_t              sts,
	input  logic [slpq_pkg::KEY_W-1:0]  in_key,
	input  logic [slpq_pkg::PAY_W-1:0]  in_payload,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic [slpq_pkg::ST_W-1:0]   rsp_status,
	output logic [slpq_pkg::KEY_W-1:0]  rsp_key,
	output logic [slpq_pkg::PAY_W-1:0]  rsp_payload,
	output logic                        rsp_last
);
	import slpq_pkg::*;

	// links hold CAPACITY as the null mark
	localparam int          LW  = $clog2(CAPACITY + 1);
	localparam int          AW  = $clog2(CAPACITY);
	localparam logic [LW-1:0] NIL = LW'(CAPACITY);

	logic [KEY_W-1:0] key_mem  [CAPACITY];
	logic [PAY_W-1:0] pay_mem  [CAPACITY];
	logic [LW-1:0]    link_mem [CAPACITY];

	logic [CAPACITY-1:0] busy_q;
	logic [LW-1:0]       head_q;
	logic [LW-1:0]       cur_q;
	logic [LW-1:0]       prev_q;
	logic [LW-1:0]       scan_q;
	logic [AW-1:0]       free_q;
	logic [KEY_W-1:0]    key_q;
	logic [PAY_W-1:0]    pay_q;

	logic [KEY_W-1:0]    rd_key_q;
	logic [PAY_W-1:0]    rd_pay_q;
	logic [LW-1:0]       rd_link_q;

	logic                out_v_q;
	logic [ST_W-1:0]     out_status_q;
	logic [KEY_W-1:0]    out_key_q;
	logic [PAY_W-1:0]    out_pay_q;
	logic                out_last_q;

	logic [LW-1:0]       rd_addr;
	logic                link_we;
	logic [AW-1:0]       link_wa;
	logic [LW-1:0]       link_wd;

	logic [ST_W-1:0]     res_status;
	logic [KEY_W-1:0]    res_key;
	logic [PAY_W-1:0]    res_pay;
	logic                res_last;

	always_comb begin
		case (cmd.rd_sel)
			RD_HEAD: rd_addr = head_q;
			RD_NEXT: rd_addr = rd_link_q;
			default: rd_addr = cur_q;
		endcase
	end

	always_comb begin
		link_we = cmd.link_new || cmd.link_prev;
		if (cmd.link_prev) begin
			link_wa = prev_q[AW-1:0];
			link_wd = LW'(free_q);
		end else begin
			link_wa = free_q;
			link_wd = cur_q;
		end
	end

	// slot memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (cmd.claim) begin
			key_mem[scan_q[AW-1:0]] <= key_q;
			pay_mem[scan_q[AW-1:0]] <= pay_q;
		end
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		rd_key_q  <= key_mem[rd_addr[AW-1:0]];
		rd_pay_q  <= pay_mem[rd_addr[AW-1:0]];
		rd_link_q <= link_mem[rd_addr[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q <= in_key;
			pay_q <= in_payload;
		end
		if (cmd.claim) begin
			free_q <= scan_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			head_q <= NIL;
			cur_q  <= NIL;
			prev_q <= NIL;
			scan_q <= '0;
		end else begin
			if (cmd.accept) begin
				cur_q  <= head_q;
				prev_q <= NIL;
				scan_q <= '0;
			end
			if (cmd.scan_inc) begin
				scan_q <= scan_q + LW'(1);
			end
			if (cmd.claim) begin
				busy_q[scan_q[AW-1:0]] <= 1'b1;
			end
			if (cmd.step) begin
				prev_q <= cur_q;
				cur_q  <= rd_link_q;
			end
			if (cmd.head_new) begin
				head_q <= LW'(free_q);
			end
			if (cmd.pop_head) begin
				busy_q[cur_q[AW-1:0]] <= 1'b0;
				head_q <= rd_link_q;
			end
		end
	end

	always_comb begin
		res_status = ST_OK;
		res_key    = '0;
		res_pay    = '0;
		res_last   = 1'b1;
		case (cmd.res_sel)
			RES_STORED: res_status = ST_OK;
			RES_FULL:   res_status = ST_FULL;
			RES_EMPTY:  res_status = ST_EMPTY;
			RES_POP: begin
				res_key = rd_key_q;
				res_pay = rd_pay_q;
			end
			RES_LIST: begin
				res_key  = rd_key_q;
				res_pay  = rd_pay_q;
				res_last = (rd_link_q == NIL);
			end
			default: res_status = ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_v_q <= 1'b1;
		end else if (rsp_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= res_status;
			out_key_q    <= res_key;
			out_pay_q    <= res_pay;
			out_last_q   <= res_last;
		end
	end

	assign rsp_valid   = out_v_q;
	assign rsp_status  = out_status_q;
	assign rsp_key     = out_key_q;
	assign rsp_payload = out_pay_q;
	assign rsp_last    = out_last_q;

	assign sts.free_hit = !busy_q[scan_q[AW-1:0]];
	assign sts.scan_end = (scan_q == NIL);
	assign sts.cur_nil  = (cur_q == NIL);
	assign sts.prev_nil = (prev_q == NIL);
	assign sts.next_nil = (rd_link_q == NIL);
	assign sts.key_less = (key_q < rd_key_q);
	assign sts.out_free = !out_v_q || rsp_ready;

endmodule

// ===== rtl/sorted_list_priority_queue.sv =====
// Insert: a free-slot scan of one slot a cycle, then a list walk of one node a
// cycle (one memory read port), then one or two link writes. Pop: the head
// entry as result. List: one entry a cycle while the response channel takes
// them. One request in work at a time.
// arst_n clears the busy map, head and control; slot memories are not cleared.
`include "sorted_list_priority_queue_macros.svh"

module sorted_list_priority_queue #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	slpq_req_if.sink    req,
	slpq_rsp_if.source  rsp
);
	import slpq_pkg::*;

	cmd_t ctl_cmd;
	sts_t dp_sts;

	slpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_op    (req.op),
		.in_ready (req.ready),
		.sts      (dp_sts),
		.cmd      (ctl_cmd)
	);

	slpq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (ctl_cmd),
		.sts         (dp_sts),
		.in_key      (req.key),
		.in_payload  (req.payload),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.rsp_status  (rsp.status),
		.rsp_key     (rsp.out_key),
		.rsp_payload (rsp.out_payload),
		.rsp_last    (rsp.last)
	);

	// no list or memory update while a new request can be taken
	`SLPQ_ASSERT(a_idle_no_update, req.ready |-> !(ctl_cmd.claim || ctl_cmd.link_new || ctl_cmd.link_prev || ctl_cmd.pop_head), "list updated while idle")
	// a result is never written over one still waiting
	`SLPQ_ASSERT_ALWAYS(a_load_when_free, ctl_cmd.out_load |-> dp_sts.out_free, "response register overrun")
	// full and empty results always end their request
	`SLPQ_ASSERT(a_error_is_last, rsp.valid && (rsp.status != ST_OK) |-> rsp.last, "error result without last")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the sorted list priority queue: insert, pop and list requests
// against an in-bench model of the slot pool, with random stalls on both channels.
// Depends on slpq_pkg, slpq_intf.sv and sorted_list_priority_queue.sv.
module testbench;
	import slpq_pkg::*;

	localparam int CAPACITY = 16;
	localparam int LINK_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam logic [LINK_W-1:0] NIL = LINK_W'(CAPACITY);
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_REQS = 225;
	localparam int CALM_TAIL = 30;
	localparam int HOLD_AFTER = 40;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} pq_req_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
		logic             last;
	} pq_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	slpq_req_if req_ch();
	slpq_rsp_if rsp_ch();

	sorted_list_priority_queue #(.CAPACITY(CAPACITY)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// model of the slot pool
	logic [KEY_W-1:0]  ent_key  [CAPACITY];
	logic [PAY_W-1:0]  ent_pay  [CAPACITY];
	logic [LINK_W-1:0] ent_link [CAPACITY];
	bit                ent_busy [CAPACITY];
	logic [LINK_W-1:0] head;

	pq_req_t pending[$];
	pq_rsp_t due_results[$];
	int      errors = 0;
	int      req_count = 0;
	int      tx_gap = 0;
	int      rx_gap = 0;
	int      hold_left = 0;
	bit      hold_done = 1'b0;

	function automatic void sorted_list_step(input pq_req_t r);
		logic [LINK_W-1:0] free_slot, cur, prv, nxt;
		int n;
		case (r.op)
			OP_INSERT: begin
				free_slot = NIL;
				for (int i = CAPACITY - 1; i >= 0; i--)
					if (!ent_busy[i]) free_slot = LINK_W'(i);
				if (free_slot == NIL) begin
					due_results.push_back('{ST_FULL, '0, '0, 1'b1});
				end else begin
					ent_key[free_slot[IDX_W-1:0]] = r.key;
					ent_pay[free_slot[IDX_W-1:0]] = r.payload;
					ent_busy[free_slot[IDX_W-1:0]] = 1'b1;
					// walk past every entry with key <= new key
					prv = NIL;
					cur = head;
					n = 0;
					while (n < CAPACITY && cur != NIL && !(r.key < ent_key[cur[IDX_W-1:0]])) begin
						prv = cur;
						cur = ent_link[cur[IDX_W-1:0]];
						n++;
					end
					if (prv == NIL) begin
						ent_link[free_slot[IDX_W-1:0]] = head;
						head = free_slot;
					end else begin
						ent_link[free_slot[IDX_W-1:0]] = ent_link[prv[IDX_W-1:0]];
						ent_link[prv[IDX_W-1:0]] = free_slot;
					end
					due_results.push_back('{ST_OK, '0, '0, 1'b1});
				end
			end
			OP_POP: begin
				if (head == NIL) begin
					due_results.push_back('{ST_EMPTY, '0, '0, 1'b1});
				end else begin
					due_results.push_back('{ST_OK, ent_key[head[IDX_W-1:0]],
						ent_pay[head[IDX_W-1:0]], 1'b1});
					ent_busy[head[IDX_W-1:0]] = 1'b0;
					head = ent_link[head[IDX_W-1:0]];
				end
			end
			OP_LIST: begin
				if (head == NIL) begin
					due_results.push_back('{ST_EMPTY, '0, '0, 1'b1});
				end else begin
					cur = head;
					n = 0;
					while (cur != NIL && n < CAPACITY) begin
						nxt = ent_link[cur[IDX_W-1:0]];
						due_results.push_back('{ST_OK, ent_key[cur[IDX_W-1:0]],
							ent_pay[cur[IDX_W-1:0]],
							(nxt == NIL || n + 1 >= CAPACITY)});
						n++;
						cur = nxt;
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void queue_req(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
			input logic [PAY_W-1:0] payload);
		pending.push_back('{op, key, payload});
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid   <= 1'b0;
			req_ch.op      <= OP_INSERT;
			req_ch.key     <= '0;
			req_ch.payload <= '0;
			tx_gap         <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				sorted_list_step(pending[0]);
				pending.pop_front();
				req_count <= req_count + 1;
			end
			if (req_ch.valid && !req_ch.ready) begin
				// hold the offered request
			end else if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				req_ch.valid <= 1'b0;
			end else if (pending.size() == 0) begin
				req_ch.valid <= 1'b0;
			end else if (pending.size() >= CALM_TAIL && $urandom_range(0, 4) == 0) begin
				tx_gap <= $urandom_range(0, 7);
				req_ch.valid <= 1'b0;
			end else begin
				req_ch.valid   <= 1'b1;
				req_ch.op      <= pending[0].op;
				req_ch.key     <= pending[0].key;
				req_ch.payload <= pending[0].payload;
			end
		end
	end

	// response ready, with one long hold-off early on
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rx_gap       <= 0;
			hold_left    <= 0;
			hold_done    <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if (!hold_done && req_count >= HOLD_AFTER) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES - 1;
			rsp_ch.ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			rsp_ch.ready <= 1'b0;
		end else if (pending.size() >= CALM_TAIL && $urandom_range(0, 4) == 0) begin
			rx_gap <= $urandom_range(0, 7);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// response monitor
	always @(posedge clk) begin
		pq_rsp_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = '{rsp_ch.status, rsp_ch.out_key, rsp_ch.out_payload, rsp_ch.last};
			if (due_results.size() == 0) begin
				$display("%0t unexpected result: status %0d key %0d payload %h last %0d",
					$time, got.status, got.key, got.payload, got.last);
				errors++;
			end else begin
				if (got !== due_results[0]) begin
					$display("%0t mismatch: expected status %0d key %0d payload %h last %0d",
						$time, due_results[0].status, due_results[0].key,
						due_results[0].payload, due_results[0].last);
					$display("%0t           actual   status %0d key %0d payload %h last %0d",
						$time, got.status, got.key, got.payload, got.last);
					errors++;
				end
				due_results.pop_front();
			end
		end
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int count, mode, run_len, pick, key_kind;
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;

		arst_n         = 1'b0;
		for (int i = 0; i < CAPACITY; i++) ent_busy[i] = 1'b0;
		head = NIL;

		// directed: empty list, key extremes, equal keys, unused code, full store
		queue_req(OP_POP, 20'd123456, 32'h1234_5678);
		queue_req(OP_LIST, '0, '0);
		queue_req(OP_INSERT, 20'd0, 32'h0000_0000);
		queue_req(OP_INSERT, 20'd999999, 32'hFFFF_FFFF);
		queue_req(OP_INSERT, 20'hFFFFF, 32'hA5A5_5A5A);
		queue_req(OP_INSERT, 20'd240101, 32'd1);
		queue_req(OP_INSERT, 20'd240101, 32'd2);
		queue_req(OP_INSERT, 20'd240101, 32'd3);
		queue_req(OP_INSERT, 20'd231231, 32'hDEAD_BEEF);
		queue_req(OP_LIST, '0, '0);
		queue_req(OP_UNUSED, 20'hFFFFF, 32'hFFFF_FFFF);
		queue_req(OP_POP, '0, '0);
		for (int i = 0; i < 10; i++)
			queue_req(OP_INSERT, 20'd240101 + 20'(i % 3), $urandom);
		queue_req(OP_INSERT, 20'd500000, 32'h5555_AAAA);
		queue_req(OP_LIST, '0, '0);

		// random: runs that lean toward filling, draining or neither
		count = 0;
		while (count < RANDOM_REQS) begin
			mode = $urandom_range(0, 2);
			run_len = $urandom_range(4, 24);
			for (int j = 0; j < run_len; j++) begin
				pick = $urandom_range(0, 99);
				if (pick < (mode == 0 ? 75 : mode == 1 ? 15 : 45)) op = OP_INSERT;
				else if (pick < 85) op = OP_POP;
				else if (pick < 97) op = OP_LIST;
				else op = OP_UNUSED;
				key_kind = $urandom_range(0, 3);
				case (key_kind)
					0: key = KEY_W'($urandom_range(0, 7));
					1: key = KEY_W'($urandom_range(0, 99) * 10000
						+ $urandom_range(1, 12) * 100 + $urandom_range(1, 31));
					2: key = KEY_W'($urandom_range(0, 999999));
					default: key = KEY_W'($urandom);
				endcase
				queue_req(op, key, $urandom);
				if (op != OP_UNUSED) count++;
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending.size() != 0 || req_ch.valid) @(negedge clk);
		while (due_results.size() != 0) @(negedge clk);
		repeat (2 * CAPACITY + 8) @(negedge clk);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== sorted_list_priority_queue.f =====
+incdir+rtl
rtl/slpq_pkg.sv
rtl/slpq_intf.sv
rtl/slpq_ctrl.sv
rtl/slpq_dp.sv
rtl/sorted_list_priority_queue.sv
tb/sv/testbench.sv
